[src/nbc_pkg.sv]
// Shared types, round constants and round functions of the NOEKEON cipher.
package nbc_pkg;

  // Number of cipher rounds.
  localparam int ROUND_COUNT = 16;

  // Round constants, one more than the round count for the closing step.
  localparam logic [7:0] RC_TABLE [ROUND_COUNT+1] = '{
    8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8, 8'hAB, 8'h4D, 8'h9A,
    8'h2F, 8'h5E, 8'hBC, 8'h63, 8'hC6, 8'h97, 8'h35, 8'h6A, 8'hD4
  };

  // Cipher state as four 32-bit words, word 0 in the top bits.
  typedef logic [0:3][31:0] blk_t;

  // Control tag that travels with every beat through the round cells.
  typedef struct packed {
    logic mode;     // 1 decrypt, 0 encrypt
    logic key_tok;  // beat derives the working key instead of carrying data
    logic bypass;   // key beat in direct mode: pass the key through unchanged
  } tag_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_KEY_HIGH     = 2'd0,
    REG_KEY_LOW      = 2'd1,
    REG_KEY_LENGTH   = 2'd2,
    REG_KEY_INDIRECT = 2'd3
  } reg_idx_e;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Linear mixing step with key addition.
  function automatic blk_t theta(blk_t k, blk_t a_in);
    blk_t        a;
    logic [31:0] t;
    a = a_in;
    t = a[0] ^ a[2];
    t = t ^ rotl(t, 24) ^ rotl(t, 8);
    a[1] = a[1] ^ t;
    a[3] = a[3] ^ t;
    a[0] = a[0] ^ k[0];
    a[1] = a[1] ^ k[1];
    a[2] = a[2] ^ k[2];
    a[3] = a[3] ^ k[3];
    t = a[1] ^ a[3];
    t = t ^ rotl(t, 24) ^ rotl(t, 8);
    a[0] = a[0] ^ t;
    a[2] = a[2] ^ t;
    return a;
  endfunction

  // Nonlinear step.
  function automatic blk_t gamma_step(blk_t a_in);
    blk_t        a;
    logic [31:0] t;
    a = a_in;
    a[1] = a[1] ^ ~(a[3] | a[2]);
    a[0] = a[0] ^ (a[2] & a[1]);
    t    = a[3];
    a[3] = a[0];
    a[0] = t;
    a[2] = a[2] ^ a[0] ^ a[1] ^ a[3];
    a[1] = a[1] ^ ~(a[3] | a[2]);
    a[0] = a[0] ^ (a[2] & a[1]);
    return a;
  endfunction

  // One full round with constants before and after the mixing step.
  function automatic blk_t one_round(blk_t k, blk_t a_in, logic [31:0] c1, logic [31:0] c2);
    blk_t a;
    a = a_in;
    a[0] = a[0] ^ c1;
    a = theta(k, a);
    a[0] = a[0] ^ c2;
    a[1] = rotl(a[1], 1);
    a[2] = rotl(a[2], 5);
    a[3] = rotl(a[3], 2);
    a = gamma_step(a);
    a[1] = rotl(a[1], 31);
    a[2] = rotl(a[2], 27);
    a[3] = rotl(a[3], 30);
    return a;
  endfunction

endpackage

[src/nbc_round_cell.sv]
// One round cell: computes one cipher round on the beat from its upstream neighbor.
module nbc_round_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               up_valid_i,
  input  nbc_pkg::tag_t      up_tag_i,
  input  nbc_pkg::blk_t      up_data_i,
  output logic               up_ready_o,
  output logic               dn_valid_o,
  output nbc_pkg::tag_t      dn_tag_o,
  output nbc_pkg::blk_t      dn_data_o,
  input  logic               dn_ready_i,
  input  nbc_pkg::blk_t      enc_key_i,
  input  nbc_pkg::blk_t      dec_key_i,
  input  logic [7:0]         rc_enc_i,
  input  logic [7:0]         rc_dec_i
);

  logic          valid_q, valid_d;
  nbc_pkg::tag_t tag_q;
  nbc_pkg::blk_t data_q, data_d;
  nbc_pkg::blk_t rnd_key;
  logic [31:0]   c1, c2;
  logic          load;

  // The cell takes a beat when it is empty or its own beat moves on.
  assign up_ready_o = ~valid_q | dn_ready_i;
  assign load       = up_valid_i & up_ready_o;

  // Key derivation runs under the all-zero key; data picks the key by direction.
  always_comb begin
    if (up_tag_i.key_tok) begin
      rnd_key = '0;
    end else if (up_tag_i.mode) begin
      rnd_key = dec_key_i;
    end else begin
      rnd_key = enc_key_i;
    end
    c1 = up_tag_i.mode ? 32'd0 : {24'd0, rc_enc_i};
    c2 = up_tag_i.mode ? {24'd0, rc_dec_i} : 32'd0;
    if (up_tag_i.bypass) begin
      data_d = up_data_i;
    end else begin
      data_d = nbc_pkg::one_round(rnd_key, up_data_i, c1, c2);
    end
  end

  // Occupancy of the cell.
  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (dn_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tag_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        tag_q <= up_tag_i;
      end
    end
  end

  // Round state needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_tag_o   = tag_q;
  assign dn_data_o  = data_q;

endmodule

[src/noekeon_block_cipher.sv]
// NOEKEON 128-bit block cipher: a chain of round cells, a closing stage and the key registers.
//
// Each block passes through sixteen round cells, one round per cell, and a closing stage that
// applies the last key mixing. A new block can be taken in every cycle, so the sustained rate is
// one block per cycle while the output is not stalled and no key derivation holds off input. A
// cell passes stall upstream only when it is full and its own beat cannot move on, so bubbles
// are squeezed out while the output waits. A write to any key register starts a key derivation
// beat that runs through the same cells under the all-zero key (or passes through unchanged in
// direct mode). Input is held off from the write until that beat leaves the closing stage.
module noekeon_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Block input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int N = nbc_pkg::ROUND_COUNT;

  // Key registers and working keys.
  logic [63:0]   key_high_q, key_low_q;
  logic [4:0]    key_len_q;
  logic          key_ind_q;
  nbc_pkg::blk_t enc_key_q, dec_key_q;
  logic          pending_q, pending_d;

  // Chain links: index 0 feeds the first cell, index i+1 is the output of cell i.
  logic          stg_valid [N+1];
  nbc_pkg::tag_t stg_tag   [N+1];
  nbc_pkg::blk_t stg_data  [N+1];
  logic          stg_ready [N+1];

  logic          cfg_wr;
  logic          key_busy;
  logic          key_hold;
  logic [4:0]    len_eff;
  logic [127:0]  key_masked;

  logic          out_valid_q, out_valid_d;
  nbc_pkg::blk_t out_data_q, fin_data;
  nbc_pkg::blk_t new_enc, new_dec;
  logic          fin_load, key_load;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      key_len_q  <= 5'd16;
      key_ind_q  <= 1'b1;
    end else if (cfg_wr) begin
      case (nbc_pkg::reg_idx_e'(paddr[4:3]))
        nbc_pkg::REG_KEY_HIGH:     key_high_q <= pwdata;
        nbc_pkg::REG_KEY_LOW:      key_low_q  <= pwdata;
        nbc_pkg::REG_KEY_LENGTH:   key_len_q  <= pwdata[4:0];
        nbc_pkg::REG_KEY_INDIRECT: key_ind_q  <= pwdata[0];
        default:                   key_ind_q  <= key_ind_q;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (nbc_pkg::reg_idx_e'(paddr[4:3]))
      nbc_pkg::REG_KEY_HIGH:     prdata = key_high_q;
      nbc_pkg::REG_KEY_LOW:      prdata = key_low_q;
      nbc_pkg::REG_KEY_LENGTH:   prdata = {59'd0, key_len_q};
      nbc_pkg::REG_KEY_INDIRECT: prdata = {63'd0, key_ind_q};
      default:                   prdata = '0;
    endcase
  end

  // Key bytes past the configured length count as zero.
  always_comb begin
    len_eff    = (key_len_q > 5'd16) ? 5'd16 : key_len_q;
    key_masked = {key_high_q, key_low_q};
    for (int j = 0; j < 16; j++) begin
      if (5'(j) >= len_eff) begin
        key_masked[127-8*j -: 8] = 8'd0;
      end
    end
  end

  // A key beat is still in the chain.
  always_comb begin
    key_busy = 1'b0;
    for (int k = 1; k <= N; k++) begin
      key_busy = key_busy | (stg_valid[k] & stg_tag[k].key_tok);
    end
  end

  assign key_hold = pending_q | key_busy | cfg_wr;

  // Chain entry: a pending key beat goes first; blocks wait for the key.
  always_comb begin
    stg_valid[0] = pending_q | (in_valid_i & ~key_hold);
    if (pending_q) begin
      stg_tag[0]  = '{mode: 1'b0, key_tok: 1'b1, bypass: ~key_ind_q};
      stg_data[0] = nbc_pkg::blk_t'(key_masked);
    end else begin
      stg_tag[0]  = '{mode: mode_i, key_tok: 1'b0, bypass: 1'b0};
      stg_data[0] = nbc_pkg::blk_t'({block_high_i, block_low_i});
    end
  end

  assign in_stall_o = key_hold | ~stg_ready[0];
  assign pending_d  = cfg_wr | (pending_q & ~stg_ready[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // The row of round cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    nbc_round_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (stg_valid[i]),
      .up_tag_i   (stg_tag[i]),
      .up_data_i  (stg_data[i]),
      .up_ready_o (stg_ready[i]),
      .dn_valid_o (stg_valid[i+1]),
      .dn_tag_o   (stg_tag[i+1]),
      .dn_data_o  (stg_data[i+1]),
      .dn_ready_i (stg_ready[i+1]),
      .enc_key_i  (enc_key_q),
      .dec_key_i  (dec_key_q),
      .rc_enc_i   (nbc_pkg::RC_TABLE[i]),
      .rc_dec_i   (nbc_pkg::RC_TABLE[N-i])
    );
  end

  // Closing stage: key beats are always taken; data waits for the output register.
  assign stg_ready[N] = stg_tag[N].key_tok | ~out_valid_q | ~out_stall_i;
  assign fin_load     = stg_valid[N] & ~stg_tag[N].key_tok & stg_ready[N];
  assign key_load     = stg_valid[N] & stg_tag[N].key_tok;

  // Last key mixing for data and for the derived key.
  always_comb begin
    nbc_pkg::blk_t a;
    a = stg_data[N];
    if (stg_tag[N].mode) begin
      fin_data    = nbc_pkg::theta(dec_key_q, a);
      fin_data[0] = fin_data[0] ^ {24'd0, nbc_pkg::RC_TABLE[0]};
    end else begin
      a[0]     = a[0] ^ {24'd0, nbc_pkg::RC_TABLE[N]};
      fin_data = nbc_pkg::theta(enc_key_q, a);
    end
    a    = stg_data[N];
    a[0] = a[0] ^ {24'd0, nbc_pkg::RC_TABLE[N]};
    if (stg_tag[N].bypass) begin
      new_enc = stg_data[N];
    end else begin
      new_enc = nbc_pkg::theta('0, a);
    end
    new_dec = nbc_pkg::theta('0, new_enc);
  end

  // Output register occupancy.
  always_comb begin
    if (fin_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      enc_key_q   <= '0;
      dec_key_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (key_load) begin
        enc_key_q <= new_enc;
        dec_key_q <= new_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_data_q <= fin_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = {out_data_q[0], out_data_q[1]};
  assign result_low_o  = {out_data_q[2], out_data_q[3]};

endmodule

[src/nbc_checker.sv]
// Port-level checks of the NOEKEON block cipher, bound to its top level.
module nbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_high_o,
  input logic [63:0] result_low_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_high_o) &&
                                   $stable(result_low_o))
    else $error("result beat changed while stalled");

  // A key write holds off blocks in the same cycle and the next one.
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |-> in_stall_o ##1 in_stall_o)
    else $error("block taken while key derivation was due");

  // No result can come out soon after reset: the chain is sixteen cells deep.
  a_reset_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni, 16) |-> !out_valid_o)
    else $error("result appeared too soon after reset");

  // The port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("configuration access was not completed");

endmodule

bind noekeon_block_cipher nbc_checker u_nbc_checker (.*);
